FILE: rtl/core/aabb_pair_contact_tracker_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the box contact tracker
// Shared property forms for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef AABB_PAIR_CONTACT_TRACKER_ASSERT_SVH
`define AABB_PAIR_CONTACT_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APCT_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APCT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/core/apct_pkg.sv
// ---------------------------------------------------------------------------
// Box contact tracker package
// Field widths, default sizes, command and event codes.
// ---------------------------------------------------------------------------
package apct_pkg;

  localparam int unsigned MAX_ENTITIES_DEF = 64;
  localparam int unsigned COORD_BITS_DEF   = 16;

  localparam int unsigned ENTITY_W   = 6;
  localparam int unsigned IN_COORD_W = 16;
  localparam int unsigned IN_HALF_W  = 15;
  localparam int unsigned EVENT_W    = 2;

  // Depth of the result queue; it covers both pipeline stages plus two entries.
  localparam int unsigned OUT_DEPTH = 4;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } command_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_BEGIN    = 2'd0,
    EV_CONTINUE = 2'd1,
    EV_END      = 2'd2
  } contact_event_e;

  typedef struct packed {
    logic [ENTITY_W-1:0] first;
    logic [ENTITY_W-1:0] second;
    contact_event_e      ev;
  } result_t;

endpackage

FILE: rtl/core/aabb_pair_contact_tracker.sv
// ---------------------------------------------------------------------------
// Axis-aligned box contact tracker
// Stores entity boxes, tests pairs for overlap and reports begin, continue and end events.
// ---------------------------------------------------------------------------
// A test result passes stage 1 and stage 2 and then enters the result queue.
// Throughput: one item per cycle while in_stall_o is low; the box memory has
// two read ports and the pair-flag memory one read and one write port, with
// forwarding between them. Reset: the pair-flag memory clears one entry a cycle,
// 2**(2*clog2(MAX_ENTITIES)) entries (4096 for 64), while in_stall_o stays high.
module aabb_pair_contact_tracker #(
  parameter int unsigned MAX_ENTITIES = apct_pkg::MAX_ENTITIES_DEF,
  parameter int unsigned COORD_BITS   = apct_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  command_i,
  input  logic [apct_pkg::ENTITY_W-1:0]         entity_a_i,
  input  logic [apct_pkg::ENTITY_W-1:0]         entity_b_i,
  input  logic signed [apct_pkg::IN_COORD_W-1:0] center_x_i,
  input  logic signed [apct_pkg::IN_COORD_W-1:0] center_y_i,
  input  logic signed [apct_pkg::IN_COORD_W-1:0] center_z_i,
  input  logic [apct_pkg::IN_HALF_W-1:0]        half_x_i,
  input  logic [apct_pkg::IN_HALF_W-1:0]        half_y_i,
  input  logic [apct_pkg::IN_HALF_W-1:0]        half_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [apct_pkg::ENTITY_W-1:0]         first_entity_o,
  output logic [apct_pkg::ENTITY_W-1:0]         second_entity_o,
  output logic [apct_pkg::EVENT_W-1:0]          contact_event_o
);
  import apct_pkg::*;

  `include "aabb_pair_contact_tracker_assert.svh"

  localparam int unsigned EW         = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
  localparam int unsigned ADDR_W     = 2 * EW;
  localparam int unsigned FLAG_DEPTH = 1 << ADDR_W;
  localparam int unsigned CW         = COORD_BITS;
  localparam int unsigned PTR_W      = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W      = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic [2:0][CW-2:0] h;
  } box_t;

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  logic              in_accept;
  logic              is_test;
  logic [EW-1:0]     ent_a;
  logic [EW-1:0]     ent_b;
  logic [EW-1:0]     pair_lo;
  logic [EW-1:0]     pair_hi;
  logic [ADDR_W-1:0] pair_addr;
  box_t              box_wr;

  logic              clr_q;
  logic [ADDR_W-1:0] clr_cnt_q;

  logic              v1_q;
  logic              v2_q;
  logic [CNT_W-1:0]  cnt_q;

  assign in_accept = in_valid_i && !in_stall_o;
  assign is_test   = (command_i == CMD_TEST);

  // Below 2**ENTITY_W entities, numbers are folded into range by a reciprocal multiply.
  if (MAX_ENTITIES >= (1 << ENTITY_W)) begin : g_ent_wide
    assign ent_a = EW'(entity_a_i);
    assign ent_b = EW'(entity_b_i);
  end else begin : g_ent_mod
    localparam int unsigned RECIP_SH = 12;
    localparam int unsigned RECIP    =
        ((1 << RECIP_SH) + MAX_ENTITIES - 1) / MAX_ENTITIES;

    function automatic logic [EW-1:0] ent_mod(input logic [ENTITY_W-1:0] v);
      logic [ENTITY_W+RECIP_SH-1:0] prod;
      logic [ENTITY_W-1:0]          quo;
      logic [ENTITY_W+RECIP_SH-1:0] back;
      logic [ENTITY_W+RECIP_SH-1:0] rem;
      prod = (ENTITY_W + RECIP_SH)'(v) * (ENTITY_W + RECIP_SH)'(RECIP);
      quo  = prod[ENTITY_W+RECIP_SH-1:RECIP_SH];
      back = (ENTITY_W + RECIP_SH)'(quo) * (ENTITY_W + RECIP_SH)'(MAX_ENTITIES);
      rem  = (ENTITY_W + RECIP_SH)'(v) - back;
      return rem[EW-1:0];
    endfunction

    assign ent_a = ent_mod(entity_a_i);
    assign ent_b = ent_mod(entity_b_i);
  end

  assign pair_lo   = (ent_a < ent_b) ? ent_a : ent_b;
  assign pair_hi   = (ent_a < ent_b) ? ent_b : ent_a;
  assign pair_addr = {pair_lo, pair_hi};

  // Centers keep their low CW bits (sign-extended first when CW is wider).
  always_comb begin
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [31:0] hx;
    logic [31:0] hy;
    logic [31:0] hz;
    cx = 32'(center_x_i);
    cy = 32'(center_y_i);
    cz = 32'(center_z_i);
    hx = 32'(half_x_i);
    hy = 32'(half_y_i);
    hz = 32'(half_z_i);
    box_wr.c[0] = cx[CW-1:0];
    box_wr.c[1] = cy[CW-1:0];
    box_wr.c[2] = cz[CW-1:0];
    box_wr.h[0] = hx[CW-2:0];
    box_wr.h[1] = hy[CW-2:0];
    box_wr.h[2] = hz[CW-2:0];
  end

  // Hold off new items while the flag memory clears or the result queue
  // could not take every result still in flight.
  assign in_stall_o = clr_q ||
      ((CNT_W + 2)'(cnt_q) + (CNT_W + 2)'(v1_q) + (CNT_W + 2)'(v2_q)
       >= (CNT_W + 2)'(OUT_DEPTH));

  // ---------------------------------------------------------------------
  // Box memory: one write port, two read ports
  // ---------------------------------------------------------------------
  box_t box_mem [MAX_ENTITIES];
  box_t box_a_q;
  box_t box_b_q;

  always_ff @(posedge clk_i) begin
    if (in_accept && !is_test) begin
      box_mem[ent_a] <= box_wr;
    end
    box_a_q <= box_mem[ent_a];
    box_b_q <= box_mem[ent_b];
  end

  // ---------------------------------------------------------------------
  // Pair-flag memory: one read port, one write port
  // ---------------------------------------------------------------------
  logic              flag_mem [FLAG_DEPTH];
  logic              flag_rd_q;
  logic              flag_we;
  logic [ADDR_W-1:0] flag_waddr;
  logic              flag_wdata;

  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    flag_rd_q <= flag_mem[pair_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      if (&clr_cnt_q) begin
        clr_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: box data arrives; form distances and extent sums
  // ---------------------------------------------------------------------
  logic [ENTITY_W-1:0] ent_a1_q;
  logic [ENTITY_W-1:0] ent_b1_q;
  logic [ADDR_W-1:0]   addr1_q;
  logic                fwd_hit1_q;
  logic                fwd_val1_q;
  logic                flag1;

  logic [2:0][CW:0]    absd1;
  logic [2:0][CW-1:0]  sum1;

  logic                touch2;
  logic [ADDR_W-1:0]   addr2_q;

  assign flag1 = fwd_hit1_q ? fwd_val1_q : flag_rd_q;

  always_comb begin
    logic [CW:0] ca;
    logic [CW:0] cb;
    logic [CW:0] d_ab;
    logic [CW:0] d_ba;
    for (int k = 0; k < 3; k++) begin
      ca   = {box_a_q.c[k][CW-1], box_a_q.c[k]};
      cb   = {box_b_q.c[k][CW-1], box_b_q.c[k]};
      d_ab = ca - cb;
      d_ba = cb - ca;
      absd1[k] = d_ab[CW] ? d_ba : d_ab;
      sum1[k]  = {1'b0, box_a_q.h[k]} + {1'b0, box_b_q.h[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    ent_a1_q   <= entity_a_i;
    ent_b1_q   <= entity_b_i;
    addr1_q    <= pair_addr;
    // A test leaving stage 2 now writes its flag at this very edge.
    fwd_hit1_q <= v2_q && (addr2_q == pair_addr);
    fwd_val1_q <= touch2;
  end

  // ---------------------------------------------------------------------
  // Stage 2: compare, decide the event and update the pair flag
  // ---------------------------------------------------------------------
  logic [ENTITY_W-1:0] ent_a2_q;
  logic [ENTITY_W-1:0] ent_b2_q;
  logic [2:0][CW:0]    absd2_q;
  logic [2:0][CW-1:0]  sum2_q;
  logic                flag2_q;
  logic [2:0]          far2;
  logic                push;
  result_t             push_res;

  always_ff @(posedge clk_i) begin
    ent_a2_q <= ent_a1_q;
    ent_b2_q <= ent_b1_q;
    addr2_q  <= addr1_q;
    absd2_q  <= absd1;
    sum2_q   <= sum1;
    flag2_q  <= (v2_q && (addr2_q == addr1_q)) ? touch2 : flag1;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      far2[k] = absd2_q[k] > {1'b0, sum2_q[k]};
    end
  end

  assign touch2 = ~|far2;

  assign flag_we    = clr_q || v2_q;
  assign flag_waddr = clr_q ? clr_cnt_q : addr2_q;
  assign flag_wdata = clr_q ? 1'b0 : touch2;

  assign push            = v2_q && (touch2 || flag2_q);
  assign push_res.first  = ent_a2_q;
  assign push_res.second = ent_b2_q;
  assign push_res.ev     = touch2 ? (flag2_q ? EV_CONTINUE : EV_BEGIN) : EV_END;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_accept && is_test;
      v2_q <= v1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  result_t          out_mem [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic             pop;
  result_t          head;

  assign out_valid_o     = (cnt_q != '0);
  assign pop             = out_valid_o && !out_stall_i;
  assign head            = out_mem[rd_ptr_q];
  assign first_entity_o  = head.first;
  assign second_entity_o = head.second;
  assign contact_event_o = head.ev;

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_mem[wr_ptr_q] <= push_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `APCT_ASSERT_NOW(a_queue_credit, clk_i, rst_ni, 1'b1,
      ((CNT_W + 2)'(cnt_q) + (CNT_W + 2)'(v1_q) + (CNT_W + 2)'(v2_q)
       <= (CNT_W + 2)'(OUT_DEPTH)), "result queue over-committed")
  `APCT_ASSERT_NOW(a_clear_idle, clk_i, rst_ni, clr_q,
      (!v1_q && !v2_q && (cnt_q == '0)), "work in flight during flag clear")
  `APCT_ASSERT_NOW(a_flag_forward, clk_i, rst_ni,
      (v2_q && $past(v2_q) && (addr2_q == $past(addr2_q))),
      (flag2_q == $past(touch2)), "pair flag not forwarded between tests")

endmodule
